// File: hdl/polyline_decimation_unit_macros.svh
// Assertion macros for the polyline decimation unit checker.
// Needs clk and rst_n in scope at the point of use.
`ifndef POLYLINE_DECIMATION_UNIT_MACROS_SVH
`define POLYLINE_DECIMATION_UNIT_MACROS_SVH

// checked only out of reset
`define PDU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("pdu check failed");

// checked on every edge, reset included
`define PDU_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("pdu check failed");

`endif

// File: hdl/pdu_pkg.sv
// Shared constants and types of the polyline decimation unit.
// No dependencies; used by controller, datapath and top level.
`default_nettype none
package pdu_pkg;
  localparam int MAX_POINTS = 64;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int COORD_W    = 16;
  localparam int TOL_W      = 15;
  localparam int PT_W       = 2 * COORD_W;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_F, S_RD_L, S_DELTA, S_LEN_MUL, S_LEN_SUM, S_SCAN_RD,
    S_SCAN_SUB, S_SCAN_MUL, S_SCAN_CMP, S_TEST_MUL, S_DECIDE, S_EMIT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_APPEND, OP_START, OP_RD_F, OP_RD_L, OP_DELTA, OP_LEN_MUL,
    OP_LEN_SUM, OP_SCAN_RD, OP_SCAN_SUB, OP_SCAN_MUL, OP_SCAN_CMP,
    OP_TEST_MUL, OP_DECIDE, OP_EMIT
  } dp_op_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_one;
    logic adjacent;
    logic last_pt;
    logic range_final;
    logic emit_done;
  } dp_status_t;
endpackage
`default_nettype wire

// File: hdl/pdu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module pdu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: hdl/pdu_ctrl.sv
// Sequencer of the polyline decimation unit: walks ranges, scan, test, emit.
// Depends on pdu_pkg.
`default_nettype none
module pdu_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_fire,
  input  wire logic                in_run,
  input  wire pdu_pkg::dp_status_t status,
  output logic                     in_ready,
  output pdu_pkg::dp_op_t          op
);
  import pdu_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          if (!in_run) begin
            op = OP_APPEND;
          end else begin
            op = OP_START;
            if (status.cnt_one) state_nxt = S_EMIT;
            else if (!status.cnt_zero) state_nxt = S_RD_F;
          end
        end
      end
      S_RD_F: begin
        op = OP_RD_F;
        state_nxt = S_RD_L;
      end
      S_RD_L: begin
        op = OP_RD_L;
        state_nxt = S_DELTA;
      end
      S_DELTA: begin
        op = OP_DELTA;
        state_nxt = S_LEN_MUL;
      end
      S_LEN_MUL: begin
        op = OP_LEN_MUL;
        state_nxt = S_LEN_SUM;
      end
      S_LEN_SUM: begin
        op = OP_LEN_SUM;
        state_nxt = status.adjacent ? S_TEST_MUL : S_SCAN_RD;
      end
      S_SCAN_RD: begin
        op = OP_SCAN_RD;
        state_nxt = S_SCAN_SUB;
      end
      S_SCAN_SUB: begin
        op = OP_SCAN_SUB;
        state_nxt = S_SCAN_MUL;
      end
      S_SCAN_MUL: begin
        op = OP_SCAN_MUL;
        state_nxt = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        op = OP_SCAN_CMP;
        state_nxt = status.last_pt ? S_TEST_MUL : S_SCAN_RD;
      end
      S_TEST_MUL: begin
        op = OP_TEST_MUL;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        op = OP_DECIDE;
        state_nxt = status.range_final ? S_EMIT : S_RD_F;
      end
      S_EMIT: begin
        op = OP_EMIT;
        if (status.emit_done) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// File: hdl/pdu_datapath.sv
// Datapath: point and range memories, cross-product unit, keep test,
// kept map and result register. Depends on pdu_pkg and pdu_ram.
`default_nettype none
module pdu_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire pdu_pkg::dp_op_t                op,
  input  wire logic [pdu_pkg::COORD_W-1:0]    in_x,
  input  wire logic [pdu_pkg::COORD_W-1:0]    in_y,
  input  wire logic                           cfg_we,
  input  wire logic [pdu_pkg::TOL_W-1:0]      cfg_data,
  input  wire logic                           out_ready,
  output logic                                out_valid,
  output logic [pdu_pkg::IDX_W-1:0]           out_idx,
  output logic                                out_last,
  output pdu_pkg::dp_status_t                 status
);
  import pdu_pkg::*;

  localparam int D_W  = COORD_W + 1;
  localparam int P_W  = 2 * D_W;
  localparam int M_W  = P_W + 1;
  localparam int T2_W = 2 * TOL_W;

  logic [CNT_W-1:0]        count_r, sp_r;
  logic [TOL_W-1:0]        tol_r;
  logic [T2_W-1:0]         tol2_r;
  logic [IDX_W-1:0]        f_r, l_r, m_r, i_r, idx_r;
  logic signed [COORD_W-1:0] xf_r, yf_r;
  logic signed [D_W-1:0]   dx_r, dy_r, px_r, py_r;
  logic signed [P_W-1:0]   pa_r, pb_r;
  logic [M_W-1:0]          len2_r, best_r;
  logic [63:0]             sq_r;
  logic [64:0]             tl_r;
  logic [MAX_POINTS-1:0]   kept_r;
  logic                    dup_r, out_valid_r, out_last_r;
  logic [IDX_W-1:0]        out_idx_r;

  logic                    pt_we;
  logic [IDX_W-1:0]        pt_raddr;
  logic [PT_W-1:0]         pt_rdata;
  logic                    stk_we;
  logic [IDX_W-1:0]        stk_raddr, stk_rdata;
  logic signed [COORD_W-1:0] rx, ry;
  logic signed [D_W-1:0]   ma1, ma2, mb1, mb2;
  logic signed [M_W-1:0]   diff;
  logic [M_W-1:0]          metric;
  logic                    len0, keep_now, close_range, slot_free;

  assign rx = signed'(pt_rdata[COORD_W-1:0]);
  assign ry = signed'(pt_rdata[PT_W-1:COORD_W]);

  assign pt_we = (op == OP_APPEND) && (count_r < CNT_W'(MAX_POINTS));

  always_comb begin
    case (op)
      OP_RD_F:    pt_raddr = f_r;
      OP_SCAN_RD: pt_raddr = i_r;
      default:    pt_raddr = l_r;
    endcase
  end

  pdu_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_pt_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (count_r[IDX_W-1:0]),
    .wdata ({in_y, in_x}),
    .raddr (pt_raddr),
    .rdata (pt_rdata)
  );

  // stack holds pending right endpoints; top is always being read
  assign stk_raddr = IDX_W'(sp_r - CNT_W'(1));

  pdu_ram #(.WIDTH(IDX_W), .DEPTH(MAX_POINTS)) u_stk_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (sp_r[IDX_W-1:0]),
    .wdata (l_r),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  assign len0 = (len2_r == '0);

  // shared multiplier operands: squares for length / coincident case, cross otherwise
  always_comb begin
    if (op == OP_LEN_MUL) begin
      ma1 = dx_r; ma2 = dx_r; mb1 = dy_r; mb2 = dy_r;
    end else if (len0) begin
      ma1 = px_r; ma2 = px_r; mb1 = py_r; mb2 = py_r;
    end else begin
      ma1 = px_r; ma2 = dy_r; mb1 = py_r; mb2 = dx_r;
    end
  end

  always_comb begin
    diff = M_W'(pa_r) - M_W'(pb_r);
    if (len0) metric = M_W'(pa_r) + M_W'(pb_r);
    else if (diff[M_W-1]) metric = M_W'(-diff);
    else metric = M_W'(diff);
  end

  always_comb begin
    if (len0) keep_now = (best_r <= M_W'(tol2_r));
    else keep_now = (best_r[M_W-1:32] == '0) && ({1'b0, sq_r} <= tl_r);
  end

  assign close_range = keep_now || (m_r == f_r);
  assign stk_we      = (op == OP_DECIDE) && !close_range;
  assign slot_free   = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      tol_r       <= '0;
      kept_r      <= '0;
      dup_r       <= 1'b0;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) tol_r <= cfg_data;
      if (op == OP_EMIT) begin
        if (slot_free) out_valid_r <= kept_r[idx_r];
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (op)
        OP_APPEND: begin
          if (pt_we) count_r <= count_r + CNT_W'(1);
        end
        OP_START: begin
          count_r <= '0;
          sp_r    <= '0;
          dup_r   <= (count_r == CNT_W'(1));
          kept_r  <= (count_r == CNT_W'(1)) ? MAX_POINTS'(1) : '0;
        end
        OP_DECIDE: begin
          if (close_range) begin
            kept_r[f_r] <= 1'b1;
            kept_r[l_r] <= 1'b1;
            if (sp_r != '0) sp_r <= sp_r - CNT_W'(1);
          end else begin
            sp_r <= sp_r + CNT_W'(1);
          end
        end
        OP_EMIT: begin
          if (slot_free && (idx_r == '0)) dup_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (op)
      OP_START: begin
        tol2_r <= tol_r * tol_r;
        f_r    <= '0;
        l_r    <= IDX_W'(count_r - CNT_W'(1));
        idx_r  <= IDX_W'(MAX_POINTS - 1);
      end
      OP_RD_L: begin
        xf_r <= rx;
        yf_r <= ry;
      end
      OP_DELTA: begin
        dx_r <= D_W'(rx) - D_W'(xf_r);
        dy_r <= D_W'(ry) - D_W'(yf_r);
      end
      OP_LEN_MUL, OP_SCAN_MUL: begin
        pa_r <= ma1 * ma2;
        pb_r <= mb1 * mb2;
      end
      OP_LEN_SUM: begin
        len2_r <= M_W'(pa_r) + M_W'(pb_r);
        i_r    <= f_r + IDX_W'(1);
        best_r <= '0;
        m_r    <= f_r;
      end
      OP_SCAN_SUB: begin
        px_r <= D_W'(rx) - D_W'(xf_r);
        py_r <= D_W'(ry) - D_W'(yf_r);
      end
      OP_SCAN_CMP: begin
        if (metric > best_r) begin
          best_r <= metric;
          m_r    <= i_r;
        end
        i_r <= i_r + IDX_W'(1);
      end
      OP_TEST_MUL: begin
        sq_r <= best_r[31:0] * best_r[31:0];
        tl_r <= tol2_r * len2_r;
      end
      OP_DECIDE: begin
        if (close_range) begin
          f_r <= l_r;
          l_r <= stk_rdata;
        end else begin
          l_r <= m_r;
        end
      end
      OP_EMIT: begin
        if (slot_free) begin
          if (kept_r[idx_r]) begin
            out_idx_r  <= idx_r;
            out_last_r <= (idx_r == '0) && !dup_r;
          end
          if (idx_r != '0) idx_r <= idx_r - IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_idx   = out_idx_r;
  assign out_last  = out_last_r;

  always_comb begin
    status.cnt_zero    = (count_r == '0);
    status.cnt_one     = (count_r == CNT_W'(1));
    status.adjacent    = ((f_r + IDX_W'(1)) == l_r);
    status.last_pt     = ((i_r + IDX_W'(1)) == l_r);
    status.range_final = close_range && (sp_r == '0);
    status.emit_done   = slot_free && (idx_r == '0) && !dup_r;
  end
endmodule
`default_nettype wire

// File: hdl/polyline_decimation_unit.sv
// Top level of the polyline decimation unit (Ramer-Douglas-Peucker).
// Depends on pdu_pkg, pdu_ctrl, pdu_datapath, pdu_ram.
//
//  channel | direction | contents
//  in_     | slave     | tdata {coord_y, coord_x}, tuser opcode
//  out_    | master    | tdata kept_index, tlast last_of_run
//  cfg_    | write     | tolerance
//
// Append: next item the cycle after. Run: per range, read both endpoints, delta,
// length multiply and sum, test multiply, decide; per interior point, read,
// subtract, multiply, compare; via the shared cross-product unit and the point
// memory's one read port. Then a kept-map sweep (index 0 twice for a single point),
// one index a cycle, stretched by out_tready stalls. Input is held off during a run.
// Reset (synchronous, rst_n low) clears the count, tolerance and output valid.
`default_nettype none
module polyline_decimation_unit (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [31:0]                in_tdata,   // coord_x [15:0], coord_y [31:16]
  input  wire logic [0:0]                 in_tuser,   // opcode
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [7:0]                      out_tdata,  // kept_index [5:0], zero fill
  output logic                            out_tlast,
  input  wire logic                       cfg_wr_en,
  input  wire logic [pdu_pkg::TOL_W-1:0]  cfg_wr_data
);
  import pdu_pkg::*;

  dp_op_t           op;
  dp_status_t       status;
  logic             in_ready;
  logic [IDX_W-1:0] out_idx;

  assign in_tready = in_ready;

  pdu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_tvalid && in_ready),
    .in_run   (in_tuser[0]),
    .status   (status),
    .in_ready (in_ready),
    .op       (op)
  );

  pdu_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .in_x      (in_tdata[COORD_W-1:0]),
    .in_y      (in_tdata[PT_W-1:COORD_W]),
    .cfg_we    (cfg_wr_en),
    .cfg_data  (cfg_wr_data),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_idx   (out_idx),
    .out_last  (out_tlast),
    .status    (status)
  );

  assign out_tdata = 8'(out_idx);
endmodule
`default_nettype wire

// File: hdl/pdu_checker.sv
// Port-level checks for the polyline decimation unit, bound to the top level.
// Depends on polyline_decimation_unit_macros.svh.
`default_nettype none
`include "polyline_decimation_unit_macros.svh"
module pdu_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tready,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tlast
);
  `PDU_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_tvalid)
  `PDU_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
  `PDU_ASSERT(a_last_is_zero, out_tvalid && out_tlast |-> out_tdata == 8'd0)
  // mid-run results mean the run is still going, so no new input
  `PDU_ASSERT(a_busy_in_run, out_tvalid && !out_tlast |-> !in_tready)
endmodule

bind polyline_decimation_unit pdu_checker u_pdu_checker (.*);
`default_nettype wire

// File: tb/polyline_decimation_unit_tb.sv
`timescale 1ns / 100ps
// Testbench for polyline_decimation_unit: point loads and decimation runs, checked
// against an in-bench Ramer-Douglas-Peucker predictor. Depends on pdu_pkg and the RTL.
`default_nettype none
module polyline_decimation_unit_tb;
  import pdu_pkg::*;

  localparam logic OPC_APPEND = 1'b0;
  localparam logic OPC_RUN    = 1'b1;
  localparam int   WATCHDOG   = 200000;
  localparam int   EXP_DEPTH  = 1024;

  typedef struct packed {
    logic        opc;
    logic [15:0] x;
    logic [15:0] y;
  } pt_item_t;

  typedef struct packed {
    logic [5:0] idx;
    logic       last;
  } kept_t;

  logic clk = 1'b0, rst_n = 1'b0;
  logic in_tvalid = 1'b0, in_tready;
  logic [31:0] in_tdata = '0;
  logic [0:0] in_tuser = '0;
  logic out_tvalid, out_tready = 1'b0, out_tlast;
  logic [7:0] out_tdata;
  logic cfg_wr_en = 1'b0;
  logic [TOL_W-1:0] cfg_wr_data = '0;

  polyline_decimation_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // predictor state
  logic signed [31:0] px_mem [MAX_POINTS];
  logic signed [31:0] py_mem [MAX_POINTS];
  int               npts;
  logic [TOL_W-1:0] tol_reg;
  kept_t            exp_mem [EXP_DEPTH];
  int               exp_wr = 0;
  int               exp_rd = 0;
  int               errors = 0;
  int               idle_cycles = 0;
  bit               hold_rx = 1'b0;

  function automatic void exp_put(input kept_t k);
    exp_mem[exp_wr % EXP_DEPTH] = k;
    exp_wr++;
  endfunction

  task automatic predict_item(input pt_item_t it);
    int stk [MAX_POINTS + 2];
    int sp;
    int f, l, m, n;
    longint dx, dy, ax, ay, c;
    longint unsigned len2, best, met, tol2;
    logic [63:0] keptmap;
    bit keep;
    if (it.opc == OPC_APPEND) begin
      if (npts < MAX_POINTS) begin
        px_mem[npts] = $signed(it.x);
        py_mem[npts] = $signed(it.y);
        npts++;
      end
      return;
    end
    n = npts;
    npts = 0;
    if (n == 0) return;
    if (n == 1) begin
      exp_put('{6'd0, 1'b0});
      exp_put('{6'd0, 1'b1});
      return;
    end
    keptmap = '0;
    tol2 = longint'(tol_reg) * longint'(tol_reg);
    stk[0] = n - 1;
    stk[1] = 0;
    sp = 2;
    while (sp > 1) begin
      sp--;
      f = stk[sp];
      sp--;
      l = stk[sp];
      dx = px_mem[l] - px_mem[f];
      dy = py_mem[l] - py_mem[f];
      len2 = dx * dx + dy * dy;
      best = 0;
      m = f;
      for (int i = f + 1; i < l; i++) begin
        ax = px_mem[i] - px_mem[f];
        ay = py_mem[i] - py_mem[f];
        if (len2 == 0) met = ax * ax + ay * ay;
        else begin
          c = ax * dy - ay * dx;
          met = (c < 0) ? -c : c;
        end
        if (met > best) begin
          best = met;
          m = i;
        end
      end
      if (len2 == 0) keep = best <= tol2;
      else keep = (best < 64'h1_0000_0000) && (best * best <= tol2 * len2);
      stk[sp] = l;
      sp++;
      if (keep || m == f) begin
        keptmap[f] = 1'b1;
        keptmap[l] = 1'b1;
      end else if (sp + 2 <= MAX_POINTS + 2) begin
        stk[sp]     = m;
        stk[sp + 1] = f;
        sp += 2;
      end
    end
    for (int i = MAX_POINTS - 1; i >= 0; i--)
      if (keptmap[i]) exp_put('{i[5:0], i == 0});
  endtask

  // output checker and watchdog
  always @(posedge clk) begin
    kept_t exp_r;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_tvalid && out_tready) begin
        if (exp_wr == exp_rd) begin
          $error("unexpected transaction: kept_index %0d", out_tdata[5:0]);
          errors++;
        end else begin
          exp_r = exp_mem[exp_rd % EXP_DEPTH];
          exp_rd++;
          if (out_tdata[5:0] !== exp_r.idx) begin
            $error("kept_index: expected %0d, got %0d", exp_r.idx, out_tdata[5:0]);
            errors++;
          end
          if (out_tlast !== exp_r.last) begin
            $error("last_of_run: expected %0d, got %0d", exp_r.last, out_tlast);
            errors++;
          end
          if (out_tdata[7:6] !== 2'b00) begin
            $error("tdata fill: expected 0, got %0d", out_tdata[7:6]);
            errors++;
          end
        end
      end
      if (idle_cycles >= WATCHDOG) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // receiver: random stalls, with an optional long hold-off
  initial begin
    int w;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_rx) begin
        out_tready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_rx = 1'b0;
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (w > 0) begin
        out_tready <= 1'b0;
        repeat (w) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  bit gappy = 1'b1;

  // valid is left high after a transaction; a gap in the next call or the drain drops it
  task automatic send_item(input pt_item_t it);
    int w;
    w = gappy ? $urandom_range(0, 14) : 0;
    if (w > 0) begin
      in_tvalid <= 1'b0;
      repeat (w) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.opc;
    in_tdata  <= {it.y, it.x};
    do @(posedge clk); while (!in_tready);
    predict_item(it);
    @(negedge clk);
  endtask

  task automatic drain_and_idle();
    in_tvalid <= 1'b0;
    while (exp_wr != exp_rd) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic set_tolerance(input logic [TOL_W-1:0] t);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= t;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    tol_reg = t;
  endtask

  function automatic pt_item_t mk(input logic o, input int x, input int y);
    mk = '{o, x[15:0], y[15:0]};
  endfunction

  pt_item_t dir_tab[] = '{
    mk(OPC_RUN, 0, 0),                                 // run with nothing loaded
    mk(OPC_APPEND, 100, -100), mk(OPC_RUN, 0, 0),      // single point: index 0 twice
    mk(OPC_APPEND, -32768, -32768), mk(OPC_APPEND, 32767, 32767),
    mk(OPC_APPEND, 32767, -32768), mk(OPC_APPEND, -32768, 32767), mk(OPC_RUN, 0, 0),
    mk(OPC_APPEND, 0, 0), mk(OPC_APPEND, 256, 256), mk(OPC_APPEND, 512, 512),
    mk(OPC_APPEND, 768, 768), mk(OPC_RUN, 0, 0),       // collinear
    mk(OPC_APPEND, 5, 5), mk(OPC_APPEND, 900, -20), mk(OPC_APPEND, 5, 5),
    mk(OPC_RUN, 0, 0),                                 // coincident endpoints
    mk(OPC_APPEND, 0, 0), mk(OPC_APPEND, 0, 0), mk(OPC_RUN, 0, 0)
  };

  function automatic int rcoord(input int mode);
    case (mode)
      0: rcoord = $signed($urandom_range(0, 65535) - 32768);
      1: rcoord = $urandom_range(0, 1) ? 32767 : -32768;
      default: rcoord = $signed($urandom_range(0, 4095)) - 2048;
    endcase
  endfunction

  initial begin
    pt_item_t it;
    int n, mode, bx, by;
    npts = 0;
    tol_reg = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // directed, first at tolerance zero
    foreach (dir_tab[i]) send_item(dir_tab[i]);
    drain_and_idle();
    set_tolerance(15'h7FFF);
    foreach (dir_tab[i]) send_item(dir_tab[i]);
    drain_and_idle();
    // random polylines with changing tolerance
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_tolerance('0);
        1: set_tolerance(15'h7FFF);
        default: set_tolerance($urandom_range(0, 3) == 0 ?
                               $urandom_range(0, 32767) : $urandom_range(0, 600));
      endcase
      gappy = (ph != 3);
      if (ph == 2) hold_rx = 1'b1;
      for (int r = 0; r < 5; r++) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 9);
        mode = $urandom_range(0, 3);
        bx = $urandom_range(0, 4000) - 2000;
        by = $urandom_range(0, 4000) - 2000;
        for (int k = 0; k < n; k++) begin
          if (mode == 3)
            it = mk(OPC_APPEND, bx + k * 64 + $urandom_range(0, 40),
                    by + $urandom_range(0, 200) - 100);
          else it = mk(OPC_APPEND, rcoord(mode), rcoord(mode));
          send_item(it);
        end
        send_item(mk(OPC_RUN, $urandom_range(0, 65535), $urandom_range(0, 65535)));
      end
      drain_and_idle();  // sender pauses until every result is back
    end
    if (errors == 0 && exp_wr == exp_rd) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire
